[sv/nearest_projected_point_select_core_defines.svh]
// Assertion macros for the nearest projected point select core.
// Included by the top level only; no other dependencies.
`ifndef NEAREST_PROJECTED_POINT_SELECT_CORE_DEFINES_SVH
`define NEAREST_PROJECTED_POINT_SELECT_CORE_DEFINES_SVH

// same-cycle implication
`define NPPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/npps_pkg.sv]
// Shared types and constants of the nearest projected point select core.
// No dependencies.
package npps_pkg;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_ACC,
      OP_PIX_SETUP,
      OP_PIX_LO,
      OP_PIX_HI,
      OP_PIX_SUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_PIX_END,
      OP_SQ_X,
      OP_SQ_Y,
      OP_DIST,
      OP_UPDATE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] term;
      logic       axis;
   } cmd_type;

   typedef struct packed {
      logic eligible;
      logic last;
      logic w_zero;
      logic rsp_busy;
   } status_type;

   localparam logic [3:0]  REG_ROW0_FIRST   = 4'd0;
   localparam logic [3:0]  REG_ROW0_SECOND  = 4'd1;
   localparam logic [3:0]  REG_ROW1_FIRST   = 4'd2;
   localparam logic [3:0]  REG_ROW1_SECOND  = 4'd3;
   localparam logic [3:0]  REG_ROW3_FIRST   = 4'd4;
   localparam logic [3:0]  REG_ROW3_SECOND  = 4'd5;
   localparam logic [3:0]  REG_SCREEN_SIZE  = 4'd6;
   localparam logic [3:0]  REG_OWN_GROUP    = 4'd7;

   localparam logic [31:0] SCREEN_RESET     = 32'd70780800;
   localparam logic signed [15:0] HEALTH_MIN = 16'sd1;
   localparam logic signed [15:0] HEALTH_MAX = 16'sd100;
   localparam logic [35:0] DIST_SAT         = 36'h8_0000_0000;
   localparam logic [35:0] DIST_ONES        = 36'hF_FFFF_FFFF;
   localparam logic [64:0] PIX_LIMIT        = 65'd262144;
   localparam logic [5:0]  INDEX_DEFAULT    = 6'd1;
   localparam logic [3:0]  TERM_LAST        = 4'd8;
   localparam logic [5:0]  DIV_LAST         = 6'd62;

endpackage

[sv/npps_ctrl.sv]
// Sequencer of the nearest projected point select core.
// Depends on npps_pkg; drives npps_datapath by command, reads its status.
module npps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  npps_pkg::status_type status,
   output npps_pkg::cmd_type   cmd
);
   import npps_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHK, ST_MUL, ST_ACC, ST_WCHK, ST_SETUP, ST_LO, ST_HI, ST_SUM,
      ST_DIV_INIT, ST_DIV, ST_PIX_END, ST_SQ_X, ST_SQ_Y, ST_DIST, ST_UPDATE, ST_EMIT
   } state_type;

   state_type  state_ff;
   logic [5:0] cnt_ff;
   logic       axis_ff;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd.op   = OP_NOP;
      cmd.term = cnt_ff[3:0];
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE:     cmd.op = req_valid ? OP_LOAD : OP_NOP;
         ST_MUL:      cmd.op = OP_MUL;
         ST_ACC:      cmd.op = OP_ACC;
         ST_SETUP:    cmd.op = OP_PIX_SETUP;
         ST_LO:       cmd.op = OP_PIX_LO;
         ST_HI:       cmd.op = OP_PIX_HI;
         ST_SUM:      cmd.op = OP_PIX_SUM;
         ST_DIV_INIT: cmd.op = OP_DIV_INIT;
         ST_DIV:      cmd.op = OP_DIV_STEP;
         ST_PIX_END:  cmd.op = OP_PIX_END;
         ST_SQ_X:     cmd.op = OP_SQ_X;
         ST_SQ_Y:     cmd.op = OP_SQ_Y;
         ST_DIST:     cmd.op = OP_DIST;
         ST_UPDATE:   cmd.op = OP_UPDATE;
         ST_EMIT:     cmd.op = status.rsp_busy ? OP_NOP : OP_EMIT;
         default:     cmd.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) state_ff <= ST_CHK;
            end
            ST_CHK: begin
               cnt_ff <= '0;
               if (status.eligible) state_ff <= ST_MUL;
               else state_ff <= status.last ? ST_EMIT : ST_IDLE;
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (cnt_ff[3:0] == TERM_LAST) begin
                  state_ff <= ST_WCHK;
               end else begin
                  cnt_ff   <= cnt_ff + 6'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_WCHK: begin
               axis_ff  <= 1'b0;
               state_ff <= status.w_zero ? ST_DIST : ST_SETUP;
            end
            ST_SETUP:    state_ff <= ST_LO;
            ST_LO:       state_ff <= ST_HI;
            ST_HI:       state_ff <= ST_SUM;
            ST_SUM:      state_ff <= ST_DIV_INIT;
            ST_DIV_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == DIV_LAST) state_ff <= ST_PIX_END;
               else cnt_ff <= cnt_ff + 6'd1;
            end
            ST_PIX_END: begin
               if (axis_ff) begin
                  state_ff <= ST_SQ_X;
               end else begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SQ_X:   state_ff <= ST_SQ_Y;
            ST_SQ_Y:   state_ff <= ST_DIST;
            ST_DIST:   state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= status.last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
               if (!status.rsp_busy) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[sv/npps_datapath.sv]
// Datapath: configuration registers, shared multiplier, restoring divider,
// running best and result register. Depends on npps_pkg.
module npps_datapath #(
   parameter int MAX_CANDIDATES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [3:0]           csr_index,
   input  logic [63:0]          csr_write_data,
   input  logic signed [31:0]   req_point_x,
   input  logic signed [31:0]   req_point_y,
   input  logic signed [31:0]   req_point_z,
   input  logic [7:0]           req_group_tag,
   input  logic signed [15:0]   req_health_value,
   input  logic                 req_is_dormant,
   input  logic [5:0]           req_candidate_index,
   input  logic                 req_last_candidate,
   output logic [5:0]           rsp_best_index,
   output logic [35:0]          rsp_best_distance_sq,
   output logic                 rsp_any_eligible,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  npps_pkg::cmd_type    cmd,
   output npps_pkg::status_type status
);
   import npps_pkg::*;

   logic [63:0]        mat_ff [6];
   logic [31:0]        screen_ff;
   logic [7:0]         own_group_ff;

   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [5:0]         idx_ff;
   logic               elig_ff, last_ff;
   logic signed [47:0] acc_ff [3];
   logic signed [63:0] prod_ff;
   logic signed [48:0] s_ff;
   logic [46:0]        aw_ff;
   logic [15:0]        size_ff, half_ff;
   logic signed [63:0] num_ff;
   logic               neg_ff;
   logic [62:0]        q_ff;
   logic [47:0]        rem_ff;
   logic [18:0]        ax_ff, ay_ff;
   logic               sat_ff;
   logic [36:0]        sq_ff;
   logic [35:0]        cand_ff;
   logic [35:0]        best_dist_ff;
   logic [5:0]         best_idx_ff;
   logic               seen_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic               elig_in;
   logic [1:0]         row;
   logic signed [47:0] v_sel, w_val, aw48, tv;
   logic [63:0]        num_mag;
   logic [48:0]        rem_sh, div_d;
   logic [63:0]        q_ext, q_signed;
   logic signed [64:0] dd, ad;
   logic               far;
   logic [37:0]        sq_sum;

   assign w_val = acc_ff[2];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL: begin
            case (cmd.term)
               4'd0:    begin mul_a = mat_ff[0][31:0];  mul_b = px_ff; end
               4'd1:    begin mul_a = mat_ff[0][63:32]; mul_b = py_ff; end
               4'd2:    begin mul_a = mat_ff[1][31:0];  mul_b = pz_ff; end
               4'd3:    begin mul_a = mat_ff[2][31:0];  mul_b = px_ff; end
               4'd4:    begin mul_a = mat_ff[2][63:32]; mul_b = py_ff; end
               4'd5:    begin mul_a = mat_ff[3][31:0];  mul_b = pz_ff; end
               4'd6:    begin mul_a = mat_ff[4][31:0];  mul_b = px_ff; end
               4'd7:    begin mul_a = mat_ff[4][63:32]; mul_b = py_ff; end
               4'd8:    begin mul_a = mat_ff[5][31:0];  mul_b = pz_ff; end
               default: begin mul_a = '0;               mul_b = '0;    end
            endcase
         end
         OP_PIX_LO: begin
            mul_a = $signed({16'b0, size_ff});
            mul_b = $signed({8'b0, s_ff[23:0]});
         end
         OP_PIX_HI: begin
            mul_a = $signed({16'b0, size_ff});
            mul_b = 32'($signed(s_ff[48:24]));
         end
         OP_SQ_X: begin
            mul_a = $signed({13'b0, ax_ff});
            mul_b = $signed({13'b0, ax_ff});
         end
         OP_SQ_Y: begin
            mul_a = $signed({13'b0, ay_ff});
            mul_b = $signed({13'b0, ay_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (cmd.term < 4'd3) row = 2'd0;
      else if (cmd.term < 4'd6) row = 2'd1;
      else row = 2'd2;
   end

   assign elig_in = (req_group_tag != own_group_ff) && (req_health_value >= HEALTH_MIN) &&
                    (req_health_value <= HEALTH_MAX) && !req_is_dormant &&
                    (req_candidate_index != 6'd0) &&
                    (32'(req_candidate_index) < MAX_CANDIDATES);

   assign v_sel   = cmd.axis ? acc_ff[1] : acc_ff[0];
   assign aw48    = w_val[47] ? -w_val : w_val;
   assign tv      = (w_val[47] ^ cmd.axis) ? -v_sel : v_sel;
   assign num_mag = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
   assign div_d   = {1'b0, aw_ff, 1'b0};
   assign rem_sh  = {rem_ff, q_ff[62]};
   assign q_ext   = {1'b0, q_ff};
   assign q_signed = neg_ff ? (~q_ext + 64'd1) : q_ext;
   assign dd      = $signed({q_signed[63], q_signed}) - $signed({49'b0, half_ff});
   assign ad      = dd[64] ? -dd : dd;
   assign far     = 65'(ad) > PIX_LIMIT;
   assign sq_sum  = {1'b0, sq_ff} + {1'b0, prod_ff[36:0]};

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            px_ff     <= req_point_x;
            py_ff     <= req_point_y;
            pz_ff     <= req_point_z;
            idx_ff    <= req_candidate_index;
            elig_ff   <= elig_in;
            last_ff   <= req_last_candidate;
            acc_ff[0] <= 48'($signed(mat_ff[1][63:32]) >>> 2);
            acc_ff[1] <= 48'($signed(mat_ff[3][63:32]) >>> 2);
            acc_ff[2] <= 48'($signed(mat_ff[5][63:32]) >>> 2);
         end
         OP_MUL, OP_PIX_LO, OP_SQ_X: prod_ff <= mul_p;
         OP_ACC: acc_ff[row] <= acc_ff[row] + 48'(prod_ff >>> 18);
         OP_PIX_SETUP: begin
            aw_ff   <= aw48[46:0];
            s_ff    <= 49'(aw48) + 49'(tv);
            size_ff <= cmd.axis ? screen_ff[31:16] : screen_ff[15:0];
            half_ff <= cmd.axis ? {1'b0, screen_ff[31:17]} : {1'b0, screen_ff[15:1]};
         end
         OP_PIX_HI: begin
            num_ff  <= cmd.axis ? (prod_ff - $signed({17'b0, aw_ff}))
                                : (prod_ff + $signed({17'b0, aw_ff}));
            prod_ff <= mul_p;
         end
         OP_PIX_SUM: num_ff <= num_ff + (prod_ff <<< 24);
         OP_DIV_INIT: begin
            neg_ff <= num_ff[63];
            q_ff   <= num_mag[62:0];
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= div_d) begin
               rem_ff <= 48'(rem_sh - div_d);
               q_ff   <= {q_ff[61:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[47:0];
               q_ff   <= {q_ff[61:0], 1'b0};
            end
         end
         OP_PIX_END: begin
            if (cmd.axis) begin
               ay_ff  <= ad[18:0];
               sat_ff <= sat_ff | far;
            end else begin
               ax_ff  <= ad[18:0];
               sat_ff <= far;
            end
         end
         OP_SQ_Y: begin
            sq_ff   <= prod_ff[36:0];
            prod_ff <= mul_p;
         end
         OP_DIST: begin
            if ((w_val == 48'sd0) || sat_ff || (sq_sum > 38'(DIST_SAT)))
               cand_ff <= DIST_SAT;
            else
               cand_ff <= sq_sum[35:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0]    <= '0;
         mat_ff[1]    <= '0;
         mat_ff[2]    <= '0;
         mat_ff[3]    <= '0;
         mat_ff[4]    <= '0;
         mat_ff[5]    <= '0;
         screen_ff    <= SCREEN_RESET;
         own_group_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_ROW0_FIRST:  mat_ff[0]    <= csr_write_data;
            REG_ROW0_SECOND: mat_ff[1]    <= csr_write_data;
            REG_ROW1_FIRST:  mat_ff[2]    <= csr_write_data;
            REG_ROW1_SECOND: mat_ff[3]    <= csr_write_data;
            REG_ROW3_FIRST:  mat_ff[4]    <= csr_write_data;
            REG_ROW3_SECOND: mat_ff[5]    <= csr_write_data;
            REG_SCREEN_SIZE: screen_ff    <= csr_write_data[31:0];
            REG_OWN_GROUP:   own_group_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= DIST_ONES;
         best_idx_ff  <= INDEX_DEFAULT;
         seen_ff      <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         if (cmd.op == OP_EMIT) rsp_valid <= 1'b1;
         else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         case (cmd.op)
            OP_UPDATE: begin
               seen_ff <= 1'b1;
               if (cand_ff < best_dist_ff) begin
                  best_dist_ff <= cand_ff;
                  best_idx_ff  <= idx_ff;
               end
            end
            OP_EMIT: begin
               rsp_best_index       <= best_idx_ff;
               rsp_best_distance_sq <= seen_ff ? best_dist_ff : '0;
               rsp_any_eligible     <= seen_ff;
               best_dist_ff         <= DIST_ONES;
               best_idx_ff          <= INDEX_DEFAULT;
               seen_ff              <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign status.eligible = elig_ff;
   assign status.last     = last_ff;
   assign status.w_zero   = (w_val == 48'sd0);
   assign status.rsp_busy = rsp_valid && rsp_stall;

endmodule

[sv/nearest_projected_point_select_core.sv]
// Top level: an eligible candidate goes through nine shared multiplies, then two
// 63-step restoring divisions, one per screen axis; with w of zero it skips the
// divisions. A last candidate also loads the result register; the next candidate is
// taken while a result still waits. Synchronous active-high reset restores the
// configuration defaults and clears the running best; no clearing pass is needed.
`include "nearest_projected_point_select_core_defines.svh"

module nearest_projected_point_select_core #(
   parameter int MAX_CANDIDATES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [7:0]         req_group_tag,
   input  logic signed [15:0] req_health_value,
   input  logic               req_is_dormant,
   input  logic [5:0]         req_candidate_index,
   input  logic               req_last_candidate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_best_index,
   output logic [35:0]        rsp_best_distance_sq,
   output logic               rsp_any_eligible
);
   import npps_pkg::*;

   cmd_type    cmd;
   status_type status;

   npps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   npps_datapath #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_point_x          (req_point_x),
      .req_point_y          (req_point_y),
      .req_point_z          (req_point_z),
      .req_group_tag        (req_group_tag),
      .req_health_value     (req_health_value),
      .req_is_dormant       (req_is_dormant),
      .req_candidate_index  (req_candidate_index),
      .req_last_candidate   (req_last_candidate),
      .rsp_best_index       (rsp_best_index),
      .rsp_best_distance_sq (rsp_best_distance_sq),
      .rsp_any_eligible     (rsp_any_eligible),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .cmd                  (cmd),
      .status               (status)
   );

   `NPPS_ASSERT_NEXT(a_busy_after_transfer, req_valid && !req_stall, req_stall, "not busy")
   `NPPS_ASSERT_NOW(a_emit_free, cmd.op == OP_EMIT, !(rsp_valid && rsp_stall), "overwritten")
   `NPPS_ASSERT_NOW(a_empty_result, rsp_valid && !rsp_any_eligible, (rsp_best_index == INDEX_DEFAULT) && (rsp_best_distance_sq == 36'd0), "bad empty")

endmodule
